// File: rtl/olist_pkg.sv
package olist_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 9;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_DELETE = 2'd3
    } olist_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_WAIT,
        ST_SCAN,
        ST_SHIFT_INIT,
        ST_SHIFT,
        ST_RESPOND
    } olist_state_t;

    typedef struct packed {
        logic load;
        logic append;
        logic read_issue;
        logic read_capture;
        logic read_fail;
        logic scan_start;
        logic scan_next;
        logic gap_at_pos;
        logic shift_init;
        logic shift_step;
        logic shift_finish;
    } olist_cmd_t;

    typedef struct packed {
        olist_kind_t kind;
        logic        not_full;
        logic        pos_valid;
        logic        list_empty;
        logic        match;
        logic        scan_more;
        logic        shift_done;
    } olist_status_t;

endpackage

// File: rtl/olist_ctrl.sv
module olist_ctrl
    import olist_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  olist_status_t status,
    output olist_cmd_t    cmd,
    output logic          busy,
    output logic          result_strobe
);

    olist_state_t state_reg;
    olist_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        busy          = 1'b1;
        result_strobe = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_RESPOND;
                case (status.kind)
                    KIND_APPEND:
                    begin
                        cmd.append = status.not_full;
                    end
                    KIND_READ:
                    begin
                        if (status.pos_valid)
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_READ_WAIT;
                        end
                        else
                        begin
                            cmd.read_fail = 1'b1;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!status.list_empty)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (status.pos_valid)
                        begin
                            cmd.gap_at_pos = 1'b1;
                            state_next     = ST_SHIFT_INIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESPOND;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_RESPOND;
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    state_next = ST_SHIFT_INIT;
                end
                else if (status.scan_more)
                begin
                    cmd.scan_next = 1'b1;
                end
                else
                begin
                    state_next = ST_RESPOND;
                end
            end
            ST_SHIFT_INIT:
            begin
                cmd.shift_init = 1'b1;
                state_next     = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (status.shift_done)
                begin
                    cmd.shift_finish = 1'b1;
                    state_next       = ST_RESPOND;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_RESPOND:
            begin
                result_strobe = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/olist_dp.sv
module olist_dp
    import olist_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  olist_cmd_t               cmd,
    input  logic [1:0]               kind,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] item_value,
    output olist_status_t            status,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     done_ok,
    output logic [LEN_W-1:0]         list_length
);

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [1:0]        kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  wr_ptr_reg;
    logic              pend_reg;
    logic [DATA_W-1:0] rv_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  wr_ptr_inc;
    logic              shift_issue;

    assign pos_ext     = CNT_W'(pos_reg);
    assign wr_ptr_inc  = wr_ptr_reg + CNT_W'(1);
    assign shift_issue = rd_ptr_reg < count_reg;

    assign status.kind       = olist_kind_t'(kind_reg);
    assign status.not_full   = count_reg < CNT_W'(CAPACITY);
    assign status.pos_valid  = pos_ext < count_reg;
    assign status.list_empty = count_reg == '0;
    assign status.match      = rd_data_reg == val_reg;
    assign status.scan_more  = wr_ptr_inc < count_reg;
    assign status.shift_done = !pend_reg && !shift_issue;

    // During a shift the read runs two entries ahead of the write, so the
    // write and read ports never touch the same entry in one cycle.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_ptr_reg[ADDR_W-1:0];
        mem_wdata = rd_data_reg;
        if (cmd.append)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[ADDR_W-1:0];
            mem_wdata = val_reg;
        end
        else if (cmd.shift_step && pend_reg)
        begin
            mem_we = 1'b1;
        end

        mem_re    = 1'b0;
        mem_raddr = rd_ptr_reg[ADDR_W-1:0];
        if (cmd.read_issue)
        begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(pos_reg);
        end
        else if (cmd.scan_start)
        begin
            mem_re    = 1'b1;
            mem_raddr = '0;
        end
        else if (cmd.scan_next)
        begin
            mem_re    = 1'b1;
            mem_raddr = wr_ptr_inc[ADDR_W-1:0];
        end
        else if (cmd.shift_step && shift_issue)
        begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            pos_reg  <= position;
            val_reg  <= item_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            pend_reg   <= 1'b0;
            rv_reg     <= '0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rv_reg <= '0;
                ok_reg <= 1'b0;
            end
            if (cmd.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
                ok_reg    <= 1'b1;
            end
            if (cmd.read_fail)
            begin
                rv_reg <= '1;
            end
            if (cmd.read_capture)
            begin
                rv_reg <= rd_data_reg;
                ok_reg <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                wr_ptr_reg <= '0;
            end
            if (cmd.scan_next)
            begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (cmd.gap_at_pos)
            begin
                wr_ptr_reg <= pos_ext;
            end
            if (cmd.shift_init)
            begin
                rd_ptr_reg <= wr_ptr_inc;
                pend_reg   <= 1'b0;
            end
            if (cmd.shift_step)
            begin
                pend_reg <= shift_issue;
                if (shift_issue)
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    wr_ptr_reg <= wr_ptr_inc;
                end
            end
            if (cmd.shift_finish)
            begin
                count_reg <= count_reg - CNT_W'(1);
                ok_reg    <= 1'b1;
            end
        end
    end

    assign read_value  = rv_reg;
    assign done_ok     = ok_reg;
    assign list_length = LEN_W'(count_reg);

endmodule

// File: rtl/ordered_list_engine_unit.sv
// Ordered list of signed 32-bit words, up to 256 entries, one operation
// per command word: append, read at position, remove first equal value,
// delete at position.
//
// A command word is taken on a rising edge where start is high and busy is
// low. busy stays high until the result word has been presented. The result
// word (read_value, done_ok, list_length) is valid for exactly one cycle
// while result_strobe is high; the receiver cannot stall, so it must take
// the word in that cycle.
//
// States from the accepting edge to the state with result_strobe high:
//   append, failed read/delete, remove on empty list: DISPATCH, RESPOND
//   successful read: DISPATCH, READ_WAIT, RESPOND
//   remove: DISPATCH, SCAN, then SHIFT_INIT and SHIFT when the value is
//           found, then RESPOND
//   delete: DISPATCH, SHIFT_INIT, SHIFT, RESPOND
// The next command is taken in the cycle after the strobe. Removal and delete
// are bounded by the single-read, single-write list memory: the search
// reads one entry a cycle and the gap is closed one entry a cycle.
// Reset empties the list at once; memory contents are left as they are.
module ordered_list_engine_unit
    import olist_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               kind,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] item_value,
    output logic                     result_strobe,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     done_ok,
    output logic [LEN_W-1:0]         list_length
);

    olist_cmd_t    cmd;
    olist_status_t status;

    olist_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    olist_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .position    (position),
        .item_value  (item_value),
        .status      (status),
        .read_value  (read_value),
        .done_ok     (done_ok),
        .list_length (list_length)
    );

endmodule
